// File: rtl/i2c_master_transaction_sequencer_defines.svh
// Assertion macros for the I2C transaction sequencer.
// Each module that uses them provides clk_i and rst_ni.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

`define I2CMTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define I2CMTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define I2CMTS_ASSERT(lbl, prop, msg)

`define I2CMTS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: rtl/i2cmts_pkg.sv
package i2cmts_pkg;

  localparam int unsigned COUNT_WIDTH = 16;

  // command codes
  localparam logic [1:0] CMD_RD   = 2'd0;
  localparam logic [1:0] CMD_WR   = 2'd1;
  localparam logic [1:0] CMD_EVT  = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  // bus status codes reported by the byte engine
  localparam logic [2:0] ST_START_SENT = 3'd0;
  localparam logic [2:0] ST_ADDR_W_ACK = 3'd1;
  localparam logic [2:0] ST_TX_ACK     = 3'd2;
  localparam logic [2:0] ST_ADDR_R_ACK = 3'd3;
  localparam logic [2:0] ST_RX_ACK     = 3'd4;
  localparam logic [2:0] ST_RX_NACK    = 3'd5;
  localparam logic [2:0] ST_OTHER      = 3'd6;

  // actions for the byte engine
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_TX      = 3'd2;
  localparam logic [2:0] ACT_RX_ACK  = 3'd3;
  localparam logic [2:0] ACT_RX_NACK = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;

  localparam logic READ_BIT = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] length;
    logic [2:0]  bus_status;
    logic [7:0]  rx_data;
    logic [7:0]  tx_data;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  out_byte;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        done_res;
    logic        failed;
    logic [15:0] transferred;
  } out_t;

endpackage

// File: rtl/i2c_master_transaction_sequencer.sv
// channel   dir  handshake                payload
// in        in   in_valid_i / in_stall_o   in_data_i  (i2cmts_pkg::in_t)
// out       out  out_valid_o / out_stall_i out_data_o (i2cmts_pkg::out_t)
// cfg       in   cfg_valid_i / cfg_ready_o cfg_data_i (target address, 7 bits)
//
// One result beat per input beat, one beat per cycle sustained while out_stall_i is low.
// A beat passes through the input register, then sequencer logic into the result register.
// A beat moves from the input register only when the result register is empty or drains.
// rst_ni clears valids and sequencer state (idle, counts zero, address zero).
// cfg writes take effect the next cycle; cfg_ready_o is always high.
module i2c_master_transaction_sequencer #(
  parameter int unsigned COUNT_WIDTH = i2cmts_pkg::COUNT_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  i2cmts_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output i2cmts_pkg::out_t  out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [6:0]        cfg_data_i
);

  logic             item_vld;
  i2cmts_pkg::in_t  item;
  logic             out_free;
  logic             fire;
  i2cmts_pkg::out_t res;

  assign fire        = item_vld & out_free;
  assign cfg_ready_o = 1'b1;

  i2cmts_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (fire),
    .vld_o      (item_vld),
    .item_o     (item)
  );

  i2cmts_core #(
    .CW (COUNT_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (item),
    .res_o      (res)
  );

  i2cmts_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/i2cmts_in_reg.sv
module i2cmts_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  i2cmts_pkg::in_t  in_data_i,
  input  logic             take_i,
  output logic             vld_o,
  output i2cmts_pkg::in_t  item_o
);

  logic            vld_q, vld_d;
  i2cmts_pkg::in_t item_q;
  logic            load;

  // register is free when empty or its beat is consumed this cycle
  assign in_stall_o = vld_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign vld_d      = load | (vld_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// File: rtl/i2cmts_core.sv
`include "i2c_master_transaction_sequencer_defines.svh"

module i2cmts_core #(
  parameter int unsigned CW = i2cmts_pkg::COUNT_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [6:0]       cfg_data_i,
  input  logic             fire_i,
  input  i2cmts_pkg::in_t  item_i,
  output i2cmts_pkg::out_t res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_ADDR,
    PH_DATA
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            is_read_q, is_read_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   limit_q, limit_d;
  logic [6:0]      addr_q;

  logic [CW-1:0]   len_c;
  logic [CW:0]     cnt_inc;
  logic [CW:0]     cnt_inc2;
  logic            more_rx;
  logic            abort;
  i2cmts_pkg::out_t res;

  always_comb begin
    len_c    = CW'(item_i.length);
    cnt_inc  = {1'b0, count_q} + {{CW{1'b0}}, 1'b1};
    // the pending receive is not the last byte
    more_rx  = cnt_inc < {1'b0, limit_q};
    cnt_inc2 = {1'b0, cnt_inc[CW-1:0]} + {{CW{1'b0}}, 1'b1};

    phase_d   = phase_q;
    is_read_d = is_read_q;
    count_d   = count_q;
    limit_d   = limit_q;
    abort     = 1'b0;
    res       = '0;

    if (item_i.cmd == i2cmts_pkg::CMD_RD || item_i.cmd == i2cmts_pkg::CMD_WR) begin
      is_read_d = (item_i.cmd == i2cmts_pkg::CMD_RD);
      count_d   = '0;
      limit_d   = len_c;
      if (is_read_d && len_c == '0) begin
        phase_d      = PH_IDLE;
        res.done_res = 1'b1;
      end else begin
        phase_d    = PH_START;
        res.action = i2cmts_pkg::ACT_START;
      end
    end else if (item_i.cmd == i2cmts_pkg::CMD_EVT && phase_q != PH_IDLE) begin
      unique case (phase_q)
        PH_START: begin
          if (item_i.bus_status != i2cmts_pkg::ST_START_SENT) begin
            abort = 1'b1;
          end else begin
            phase_d      = PH_ADDR;
            res.action   = i2cmts_pkg::ACT_TX;
            res.out_byte = {addr_q, is_read_q ? i2cmts_pkg::READ_BIT : 1'b0};
          end
        end
        PH_ADDR, PH_DATA: begin
          if (is_read_q) begin
            if (phase_q == PH_ADDR) begin
              if (item_i.bus_status != i2cmts_pkg::ST_ADDR_R_ACK) begin
                abort = 1'b1;
              end else begin
                phase_d    = PH_DATA;
                res.action = more_rx ? i2cmts_pkg::ACT_RX_ACK : i2cmts_pkg::ACT_RX_NACK;
              end
            end else if (item_i.bus_status !=
                         (more_rx ? i2cmts_pkg::ST_RX_ACK : i2cmts_pkg::ST_RX_NACK)) begin
              abort = 1'b1;
            end else begin
              count_d      = cnt_inc[CW-1:0];
              res.rx_valid = 1'b1;
              res.rx_byte  = item_i.rx_data;
              if (count_d < limit_q) begin
                res.action = (cnt_inc2 < {1'b0, limit_q}) ? i2cmts_pkg::ACT_RX_ACK
                                                          : i2cmts_pkg::ACT_RX_NACK;
              end else begin
                phase_d      = PH_IDLE;
                res.action   = i2cmts_pkg::ACT_STOP;
                res.done_res = 1'b1;
              end
            end
          end else begin
            if (item_i.bus_status != ((phase_q == PH_ADDR) ? i2cmts_pkg::ST_ADDR_W_ACK
                                                          : i2cmts_pkg::ST_TX_ACK)) begin
              abort = 1'b1;
            end else if (count_q < limit_q) begin
              // a write byte counts once it is issued
              phase_d      = PH_DATA;
              count_d      = cnt_inc[CW-1:0];
              res.action   = i2cmts_pkg::ACT_TX;
              res.out_byte = item_i.tx_data;
            end else begin
              phase_d      = PH_IDLE;
              res.action   = i2cmts_pkg::ACT_STOP;
              res.done_res = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    if (abort) begin
      phase_d      = PH_IDLE;
      res          = '0;
      res.done_res = 1'b1;
      res.failed   = 1'b1;
    end
    res.transferred = 16'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      is_read_q <= 1'b0;
      count_q   <= '0;
      limit_q   <= '0;
      addr_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        addr_q <= cfg_data_i;
      end
      if (fire_i) begin
        phase_q   <= phase_d;
        is_read_q <= is_read_d;
        count_q   <= count_d;
        limit_q   <= limit_d;
      end
    end
  end

  assign res_o = res;

  `I2CMTS_ASSERT(a_fail_is_done, (fire_i && res.failed) |-> res.done_res,
                 "abort without done")
  `I2CMTS_ASSERT_NEVER(a_rx_on_write, fire_i && res.rx_valid && !is_read_q,
                       "received byte during a write")
  `I2CMTS_ASSERT(a_count_bound, (phase_q != PH_IDLE) |-> (count_q <= limit_q),
                 "byte count past limit")
  `I2CMTS_ASSERT(a_idle_quiet,
                 (fire_i && phase_q == PH_IDLE && item_i.cmd == i2cmts_pkg::CMD_EVT)
                 |=> (phase_q == PH_IDLE),
                 "status event left idle")

endmodule

// File: rtl/i2cmts_out_reg.sv
module i2cmts_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  i2cmts_pkg::out_t  res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output i2cmts_pkg::out_t  out_data_o
);

  logic             vld_q, vld_d;
  i2cmts_pkg::out_t data_q;

  // free when empty or the held beat leaves this cycle
  assign free_o = ~vld_q | ~out_stall_i;
  assign vld_d  = fire_i | (vld_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule
